/* sv/rrsa_pkg.sv */
`timescale 1ns / 1ps

package rrsa_pkg;

    localparam int TIME_W  = 32;
    localparam int BUSY_W  = TIME_W + 1;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 5;
    localparam int SRV_W   = 4;
    localparam int MASK_W  = 16;

    localparam logic [CFG_W-1:0]   NUM_SERVERS_RST = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [BUSY_W-1:0]  busy_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

/* sv/rrsa_pick.sv */
`timescale 1ns / 1ps

module rrsa_pick
    import rrsa_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int IDX_W       = 4,
    parameter int KW          = 5
) (
    input  busy_t            busy_until [MAX_SERVERS],
    input  time_t            arrival_time,
    input  logic [KW-1:0]    num_active,
    input  logic [IDX_W-1:0] start,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    logic [MAX_SERVERS-1:0] free_vec;
    logic [MAX_SERVERS-1:0] upper_vec;
    logic [MAX_SERVERS-1:0] pick_vec;

    always_comb begin
        for (int j = 0; j < MAX_SERVERS; j++) begin
            free_vec[j]  = (KW'(j) < num_active) && (busy_until[j] <= {1'b0, arrival_time});
            upper_vec[j] = free_vec[j] && (KW'(j) >= KW'(start));
        end
    end

    // prefer servers at or after the rotation point, else wrap to the lowest
    assign pick_vec = (|upper_vec) ? upper_vec : free_vec;
    assign found    = |free_vec;

    always_comb begin
        idx = '0;
        for (int j = MAX_SERVERS - 1; j >= 0; j--) begin
            if (pick_vec[j]) begin
                idx = IDX_W'(j);
            end
        end
    end

endmodule

/* sv/round_robin_server_assigner.sv */
`timescale 1ns / 1ps

// Round-robin server assigner. Request i is offered to server i mod k first and
// then to the following servers cyclically; it goes to the first one whose busy-until
// time is at most the arrival time, else it is dropped (the rotation still advances).
// Each request yields one result beat with the outcome, the assigned server's
// saturating count, the running maximum count and a mask of the busiest servers.
// Throughput is one request per clock while m_ready does not stall the result beat;
// a request passes from the input register through the parallel busy-until compares
// and rotating priority encoder, which also update the server state, to the result beat.
// num_servers (cfg_we/cfg_wdata) must be written only while the block is idle.
module round_robin_server_assigner
    import rrsa_pkg::*;
#(
    parameter int MAX_SERVERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TIME_W-1:0]   s_arrival_time,
    input  logic [TIME_W-1:0]   s_duration,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_dropped,
    output logic [SRV_W-1:0]    m_server,
    output logic [COUNT_W-1:0]  m_server_count,
    output logic [COUNT_W-1:0]  m_max_count,
    output logic [MASK_W-1:0]   m_busiest_mask
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int KW    = ($clog2(MAX_SERVERS + 1) > CFG_W) ? $clog2(MAX_SERVERS + 1) : CFG_W;

    logic [CFG_W-1:0] num_servers_reg;

    logic  in_valid_reg;
    time_t arrival_reg;
    time_t duration_reg;

    busy_t            busy_reg   [MAX_SERVERS];
    busy_t            busy_next  [MAX_SERVERS];
    count_t           count_reg  [MAX_SERVERS];
    count_t           count_next [MAX_SERVERS];
    logic [IDX_W-1:0] rot_reg;
    logic [IDX_W-1:0] rot_next;
    count_t           best_reg;
    count_t           best_next;

    logic             out_valid_reg;
    logic             dropped_reg;
    logic [SRV_W-1:0] server_reg;
    count_t           server_count_reg;
    count_t           max_count_reg;
    logic [MASK_W-1:0] mask_reg;

    logic                   take;
    logic [KW-1:0]          num_active;
    logic [KW-1:0]          cfg_ext;
    logic [IDX_W-1:0]       start;
    logic [KW-1:0]          start_inc;
    logic                   found;
    logic [IDX_W-1:0]       idx;
    count_t                 new_count;
    logic [MAX_SERVERS-1:0] eq_mask;
    logic [MAX_SERVERS-1:0] idx_onehot;
    logic [MAX_SERVERS-1:0] mask_next;
    logic [MAX_SERVERS+MASK_W-1:0] mask_ext;
    logic [IDX_W+SRV_W-1:0] idx_ext;

    assign take    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || take;

    // clamp the server count to 1..MAX_SERVERS
    assign cfg_ext = KW'(num_servers_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            num_active = KW'(1);
        end else if (cfg_ext > KW'(MAX_SERVERS)) begin
            num_active = KW'(MAX_SERVERS);
        end else begin
            num_active = cfg_ext;
        end
    end

    assign start     = (KW'(rot_reg) < num_active) ? rot_reg : '0;
    assign start_inc = KW'(start) + KW'(1);
    assign rot_next  = (start_inc >= num_active) ? '0 : IDX_W'(start_inc);

    rrsa_pick #(
        .MAX_SERVERS (MAX_SERVERS),
        .IDX_W       (IDX_W),
        .KW          (KW)
    ) u_pick (
        .busy_until   (busy_reg),
        .arrival_time (arrival_reg),
        .num_active   (num_active),
        .start        (start),
        .found        (found),
        .idx          (idx)
    );

    assign new_count = (count_reg[idx] == COUNT_MAX) ? COUNT_MAX : count_reg[idx] + 1'b1;

    always_comb begin
        for (int j = 0; j < MAX_SERVERS; j++) begin
            eq_mask[j]    = (KW'(j) < num_active) && (count_reg[j] == best_reg);
            idx_onehot[j] = (IDX_W'(j) == idx);
            busy_next[j]  = busy_reg[j];
            count_next[j] = count_reg[j];
        end
        if (found) begin
            busy_next[idx]  = {1'b0, arrival_reg} + {1'b0, duration_reg};
            count_next[idx] = new_count;
        end
    end

    // busiest set follows from the old equal set and the one count that moved
    always_comb begin
        best_next = best_reg;
        mask_next = eq_mask;
        if (found) begin
            if (new_count > best_reg) begin
                best_next = new_count;
                mask_next = idx_onehot;
            end else if (new_count == best_reg) begin
                mask_next = eq_mask | idx_onehot;
            end
        end
    end

    assign mask_ext = {{MASK_W{1'b0}}, mask_next};
    assign idx_ext  = {{SRV_W{1'b0}}, idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_servers_reg <= NUM_SERVERS_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            rot_reg         <= '0;
            best_reg        <= '0;
            for (int j = 0; j < MAX_SERVERS; j++) begin
                busy_reg[j]  <= '0;
                count_reg[j] <= '0;
            end
        end else begin
            if (cfg_we) begin
                num_servers_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (take) begin
                in_valid_reg <= 1'b0;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
                rot_reg       <= rot_next;
                best_reg      <= best_next;
                for (int j = 0; j < MAX_SERVERS; j++) begin
                    busy_reg[j]  <= busy_next[j];
                    count_reg[j] <= count_next[j];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            arrival_reg  <= s_arrival_time;
            duration_reg <= s_duration;
        end
        if (take) begin
            dropped_reg      <= !found;
            server_reg       <= found ? idx_ext[SRV_W-1:0] : '0;
            server_count_reg <= found ? new_count : '0;
            max_count_reg    <= best_next;
            mask_reg         <= mask_ext[MASK_W-1:0];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_dropped      = dropped_reg;
    assign m_server       = server_reg;
    assign m_server_count = server_count_reg;
    assign m_max_count    = max_count_reg;
    assign m_busiest_mask = mask_reg;

endmodule

/* sv/rrsa_checker.sv */
`timescale 1ns / 1ps

module rrsa_checker
    import rrsa_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_dropped,
    input logic [SRV_W-1:0]   m_server,
    input logic [COUNT_W-1:0] m_server_count,
    input logic [COUNT_W-1:0] m_max_count,
    input logic [MASK_W-1:0]  m_busiest_mask
);

    // a stalled result beat keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dropped) && $stable(m_server)
            && $stable(m_server_count) && $stable(m_max_count) && $stable(m_busiest_mask))
        else $error("result beat changed while stalled");

    // a dropped request reports no server and no count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_server == '0 && m_server_count == '0)
        else $error("dropped beat carries a server or count");

    // a served request has a nonzero count bounded by the running maximum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dropped |-> m_server_count != '0 && m_server_count <= m_max_count)
        else $error("served count out of range");

    // the running maximum never falls between delivered beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |-> m_max_count >= $past(m_max_count))
        else $error("running maximum decreased");

endmodule

bind round_robin_server_assigner rrsa_checker u_rrsa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_dropped      (m_dropped),
    .m_server       (m_server),
    .m_server_count (m_server_count),
    .m_max_count    (m_max_count),
    .m_busiest_mask (m_busiest_mask)
);

/* bench/round_robin_server_assigner_tb.sv */
`timescale 1ns / 1ps

module round_robin_server_assigner_tb;
    import rrsa_pkg::*;

    localparam int MAX_SRV        = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        time_t arrival;
        time_t duration;
    } request_t;

    typedef struct packed {
        logic               dropped;
        logic [SRV_W-1:0]   server;
        count_t             server_count;
        count_t             max_count;
        logic [MASK_W-1:0]  busiest_mask;
    } assignment_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    time_t              s_arrival_time = '0;
    time_t              s_duration     = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_dropped;
    logic [SRV_W-1:0]   m_server;
    count_t             m_server_count;
    count_t             m_max_count;
    logic [MASK_W-1:0]  m_busiest_mask;

    // predictor state
    busy_t              srv_busy_until [MAX_SRV];
    count_t             srv_handled [MAX_SRV];
    int unsigned        rot_start    = 0;
    count_t             best_handled = '0;
    logic [CFG_W-1:0]   srv_cfg      = NUM_SERVERS_RST;

    request_t           request_q [$];
    assignment_t        assignment_q [$];
    request_t           drive_req;
    logic               in_beat_taken = 1'b0;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    int unsigned        idle_cycles   = 0;
    int unsigned        errors        = 0;
    time_t              time_base     = 32'd300;

    round_robin_server_assigner #(
        .MAX_SERVERS    (MAX_SRV)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_arrival_time (s_arrival_time),
        .s_duration     (s_duration),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dropped      (m_dropped),
        .m_server       (m_server),
        .m_server_count (m_server_count),
        .m_max_count    (m_max_count),
        .m_busiest_mask (m_busiest_mask)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int j = 0; j < MAX_SRV; j++) begin
            srv_busy_until[j] = '0;
            srv_handled[j]    = '0;
        end
    end

    // zero means one server, anything above the built count is clipped
    function automatic int unsigned active_count(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SRV) return MAX_SRV;
        return v;
    endfunction

    function automatic assignment_t assign_request(input request_t r);
        assignment_t res;
        int unsigned k;
        int unsigned start;
        int unsigned j;
        int unsigned idx;
        logic found;
        k     = active_count(srv_cfg);
        start = (rot_start < k) ? rot_start : 0;
        found = 1'b0;
        idx   = 0;
        res   = '0;
        for (int unsigned step = 0; step < k; step++) begin
            j = start + step;
            if (j >= k) j -= k;
            if (!found && srv_busy_until[j] <= {1'b0, r.arrival}) begin
                idx   = j;
                found = 1'b1;
            end
        end
        if (found) begin
            srv_busy_until[idx] = {1'b0, r.arrival} + {1'b0, r.duration};
            if (srv_handled[idx] != COUNT_MAX) srv_handled[idx] = srv_handled[idx] + 1;
            if (srv_handled[idx] > best_handled) best_handled = srv_handled[idx];
            res.server       = idx[SRV_W-1:0];
            res.server_count = srv_handled[idx];
        end
        rot_start = (start + 1 >= k) ? 0 : start + 1;
        for (int unsigned step = 0; step < k && step < MASK_W; step++) begin
            if (srv_handled[step] == best_handled) res.busiest_mask[step] = 1'b1;
        end
        res.dropped   = !found;
        res.max_count = best_handled;
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
            errors++;
        end
    endtask

    // driver: new beat only once the previous one has gone
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_beat_taken) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drive_req = request_q.pop_front();
                    s_valid        <= 1'b1;
                    s_arrival_time <= drive_req.arrival;
                    s_duration     <= drive_req.duration;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor: check results first so a stray beat is never masked
    always @(posedge aclk) begin
        in_beat_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (assignment_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got server %0d",
                             $time, m_server);
                    errors++;
                end else begin
                    assignment_t want;
                    want = assignment_q.pop_front();
                    check_field("dropped", want.dropped, m_dropped);
                    check_field("server", want.server, m_server);
                    check_field("server_count", want.server_count, m_server_count);
                    check_field("max_count", want.max_count, m_max_count);
                    check_field("busiest_mask", want.busiest_mask, m_busiest_mask);
                end
            end
            if (s_valid && s_ready) begin
                assignment_q.insert(assignment_q.size(),
                                    assign_request('{s_arrival_time, s_duration}));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (request_q.size() == 0 && !s_valid && assignment_q.size() == 0)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("round_robin_server_assigner verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_request(input time_t arrival, input time_t duration);
        request_t r;
        r.arrival  = arrival;
        r.duration = duration;
        request_q.insert(request_q.size(), r);
    endtask

    task automatic drain;
        while (request_q.size() > 0 || s_valid || assignment_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_servers(input logic [CFG_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        srv_cfg    = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // mostly rising arrival times with durations sized to the server count
    task automatic push_traffic(input int n, input logic noisy);
        int unsigned k;
        int unsigned sel;
        k = active_count(srv_cfg);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (noisy && sel < 5) begin
                push_request($urandom, $urandom);
            end else if (sel == 0) begin
                push_request(time_base - $urandom_range(0, 40), $urandom_range(0, 8));
            end else if (sel == 1) begin
                push_request(time_base, '0);
            end else begin
                time_base = time_base + $urandom_range(0, 3);
                push_request(time_base, $urandom_range(0, 6 * k));
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] v, input int n,
                             input int unsigned idle, input int unsigned stall,
                             input logic noisy);
        write_servers(v);
        send_idle_pct = idle;
        stall_pct     = stall;
        push_traffic(n, noisy);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // three servers: immediate reuse, all busy, free at equal time
        write_servers(5'd3);
        push_request(32'd0, 32'd0);
        push_request(32'd0, 32'd10);
        push_request(32'd0, 32'd10);
        push_request(32'd0, 32'd10);
        push_request(32'd5, 32'd1);
        push_request(32'd10, 32'd0);
        push_request(32'd9, 32'd3);
        push_request(32'd11, 32'd4);

        // zero servers acts as one, rotation left out of range
        write_servers(5'd0);
        push_request(32'd20, 32'd5);
        push_request(32'd22, 32'd1);
        push_request(32'd25, 32'd0);

        // oversized count clips to all servers
        write_servers(5'd31);
        for (int i = 0; i < 7; i++) push_request(32'd30, 32'd100);

        // lowering k below the rotation restarts at server 0
        write_servers(5'd2);
        push_request(32'd200, 32'd1);
        push_request(32'd200, 32'd1);
        push_request(32'd201, 32'd0);

        run_phase(5'd16, 220, 0, 0, 1'b0);
        run_phase(5'd1, 180, 57, 0, 1'b0);
        run_phase(5'd7, 220, 0, 57, 1'b0);
        run_phase(5'd17, 220, 38, 38, 1'b0);
        run_phase(5'd4, 200, 0, 0, 1'b0);
        run_phase(5'd12, 220, 57, 0, 1'b0);
        run_phase(5'd5, 200, 0, 57, 1'b0);

        // field extremes last, since huge busy-until times retire servers
        write_servers(5'd16);
        send_idle_pct = 0;
        stall_pct     = 0;
        push_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(32'hFFFF_FFFF, 32'h0);
        push_request(32'h0, 32'hFFFF_FFFF);
        push_request(32'h8000_0000, 32'h8000_0000);
        push_request(32'hFFFF_FFFF, 32'h1);
        run_phase(5'd16, 150, 38, 38, 1'b1);
        drain();

        if (errors == 0) begin
            $display("round_robin_server_assigner verification clean");
        end else begin
            $display("round_robin_server_assigner verification failed");
        end
        $finish;
    end

endmodule
